/* rtl/i2cpp_pkg.sv */
// ----------------------------------------------------------------------------
// i2cpp_pkg
// Shared types and constants of the I2C pressure sensor poller.
// ----------------------------------------------------------------------------
package i2cpp_pkg;

    localparam int READ_BYTES = 4;

    localparam int RAW_W   = 24;
    localparam int PRESS_W = 20;
    localparam int GAIN_W  = 32;
    localparam int DIFF_W  = RAW_W + 1;
    localparam int PP_W    = DIFF_W + GAIN_W / 2 + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W;
    localparam int SHIFT   = 24;
    localparam int Q_W     = PROD_W - SHIFT;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    localparam logic [1:0] LAST_BYTE = 2'(READ_BYTES - 1);

    // Configuration register indexes
    localparam logic [2:0] CFG_DEV_ADDR = 3'd0;
    localparam logic [2:0] CFG_MEAS_CMD = 3'd1;
    localparam logic [2:0] CFG_WAIT     = 3'd2;
    localparam logic [2:0] CFG_ZERO     = 3'd3;
    localparam logic [2:0] CFG_GAIN     = 3'd4;

    // Status codes
    localparam logic [1:0] WST_OK       = 2'd0;
    localparam logic [1:0] WST_ADDR_NAK = 2'd1;
    localparam logic [1:0] WST_CMD_NAK  = 2'd2;

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(524287);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(524288);

    typedef struct packed {
        logic [6:0]         device_address;
        logic [7:0]         measure_command;
        logic [23:0]        wait_ticks;
        logic signed [23:0] zero_code;
        logic [31:0]        gain_q32;
    } cfg_t;

    // Result of the bus sequencer for one word
    typedef struct packed {
        logic                   scl;
        logic                   sda;
        logic                   drv;
        logic                   busy;
        logic                   done;
        logic [1:0]             wstat;
        logic                   rstat;
        logic signed [RAW_W-1:0] raw;
    } seq_res_t;

    typedef struct packed {
        seq_res_t                  seq;
        logic signed [PRESS_W-1:0] pressure;
    } res_t;

endpackage

/* rtl/i2cpp_cfg.sv */
// ----------------------------------------------------------------------------
// i2cpp_cfg
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module i2cpp_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output i2cpp_pkg::cfg_t    cfg
);
    import i2cpp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address  <= 7'd120;
            cfg_reg.measure_command <= 8'd172;
            cfg_reg.wait_ticks      <= 24'd25000;
            cfg_reg.zero_code       <= 24'sd1677722;
            cfg_reg.gain_q32        <= 32'd640000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEV_ADDR: cfg_reg.device_address  <= cfg_data[6:0];
                CFG_MEAS_CMD: cfg_reg.measure_command <= cfg_data[7:0];
                CFG_WAIT:     cfg_reg.wait_ticks      <= cfg_data[23:0];
                CFG_ZERO:     cfg_reg.zero_code       <= $signed(cfg_data[23:0]);
                CFG_GAIN:     cfg_reg.gain_q32        <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/i2cpp_seq.sv */
// ----------------------------------------------------------------------------
// i2cpp_seq
// Bus sequencer: one phase per tick, result held in the first pipe register.
// ----------------------------------------------------------------------------
module i2cpp_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  i2cpp_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic                 sda_sample,
    output logic                 st1_valid,
    input  logic                 st1_ready,
    output i2cpp_pkg::seq_res_t  st1
);
    import i2cpp_pkg::*;

    typedef enum logic [25:0] {
        PH_IDLE     = 26'd1 << 0,
        PH_WSTART   = 26'd1 << 1,
        PH_WADDR_LO = 26'd1 << 2,
        PH_WADDR_HI = 26'd1 << 3,
        PH_WAACK_LO = 26'd1 << 4,
        PH_WAACK_HI = 26'd1 << 5,
        PH_WCMD_LO  = 26'd1 << 6,
        PH_WCMD_HI  = 26'd1 << 7,
        PH_WCACK_LO = 26'd1 << 8,
        PH_WCACK_HI = 26'd1 << 9,
        PH_WSTOP_A  = 26'd1 << 10,
        PH_WSTOP_B  = 26'd1 << 11,
        PH_WSTOP_C  = 26'd1 << 12,
        PH_WAIT     = 26'd1 << 13,
        PH_RSTART   = 26'd1 << 14,
        PH_RADDR_LO = 26'd1 << 15,
        PH_RADDR_HI = 26'd1 << 16,
        PH_RAACK_LO = 26'd1 << 17,
        PH_RAACK_HI = 26'd1 << 18,
        PH_RDATA_LO = 26'd1 << 19,
        PH_RDATA_HI = 26'd1 << 20,
        PH_MACK_LO  = 26'd1 << 21,
        PH_MACK_HI  = 26'd1 << 22,
        PH_RSTOP_A  = 26'd1 << 23,
        PH_RSTOP_B  = 26'd1 << 24,
        PH_RSTOP_C  = 26'd1 << 25
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  bit_reg,    bit_next;
    logic [1:0]  byte_reg,   byte_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [23:0] raw_reg,    raw_next;
    logic [23:0] wait_reg,   wait_next;
    logic [1:0]  werr_reg,   werr_next;
    logic        rerr_reg,   rerr_next;
    logic        scl_reg,    scl_next;
    logic        sda_reg,    sda_next;
    logic        drv_reg,    drv_next;
    logic        done;
    logic        last;
    logic        accept;
    logic        st1_valid_reg, st1_valid_next;
    seq_res_t    st1_reg,    st1_next;

    assign in_ready  = !st1_valid_reg || st1_ready;
    assign accept    = in_valid && in_ready;
    assign last      = byte_reg == LAST_BYTE;
    assign st1_valid = st1_valid_reg;
    assign st1       = st1_reg;

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        raw_next   = raw_reg;
        wait_next  = wait_reg;
        werr_next  = werr_reg;
        rerr_next  = rerr_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        done       = 1'b0;
        if (command) begin
            if (phase_reg == PH_IDLE) begin
                raw_next   = '0;
                werr_next  = WST_OK;
                rerr_next  = 1'b0;
                bit_next   = '0;
                byte_next  = '0;
                phase_next = PH_WSTART;
            end
        end else begin
            case (phase_reg)
                PH_WSTART, PH_RSTART: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                    shift_next = {cfg.device_address, phase_reg == PH_RSTART};
                    bit_next   = '0;
                    phase_next = (phase_reg == PH_RSTART) ? PH_RADDR_LO : PH_WADDR_LO;
                end
                PH_WADDR_LO, PH_WCMD_LO, PH_RADDR_LO: begin
                    scl_next = 1'b0;
                    sda_next = shift_reg[7];
                    drv_next = 1'b1;
                    case (phase_reg)
                        PH_WADDR_LO: phase_next = PH_WADDR_HI;
                        PH_WCMD_LO:  phase_next = PH_WCMD_HI;
                        default:     phase_next = PH_RADDR_HI;
                    endcase
                end
                PH_WADDR_HI, PH_WCMD_HI, PH_RADDR_HI: begin
                    scl_next   = 1'b1;
                    sda_next   = shift_reg[7];
                    drv_next   = 1'b1;
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_reg + 3'd1;
                    case (phase_reg)
                        PH_WADDR_HI:
                            phase_next = (bit_reg == 3'd7) ? PH_WAACK_LO : PH_WADDR_LO;
                        PH_WCMD_HI:
                            phase_next = (bit_reg == 3'd7) ? PH_WCACK_LO : PH_WCMD_LO;
                        default:
                            phase_next = (bit_reg == 3'd7) ? PH_RAACK_LO : PH_RADDR_LO;
                    endcase
                end
                PH_WAACK_LO, PH_WCACK_LO, PH_RAACK_LO, PH_RDATA_LO: begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    drv_next = 1'b0;
                    case (phase_reg)
                        PH_WAACK_LO: phase_next = PH_WAACK_HI;
                        PH_WCACK_LO: phase_next = PH_WCACK_HI;
                        PH_RAACK_LO: phase_next = PH_RAACK_HI;
                        default:     phase_next = PH_RDATA_HI;
                    endcase
                end
                PH_WAACK_HI: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b0;
                    if (sda_sample) begin
                        werr_next  = WST_ADDR_NAK;
                        phase_next = PH_WSTOP_A;
                    end else begin
                        shift_next = cfg.measure_command;
                        bit_next   = '0;
                        phase_next = PH_WCMD_LO;
                    end
                end
                PH_WCACK_HI: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b0;
                    if (sda_sample) begin
                        werr_next = WST_CMD_NAK;
                    end
                    phase_next = PH_WSTOP_A;
                end
                PH_WSTOP_A, PH_RSTOP_A: begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                    phase_next = (phase_reg == PH_RSTOP_A) ? PH_RSTOP_B : PH_WSTOP_B;
                end
                PH_WSTOP_B, PH_RSTOP_B: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                    phase_next = (phase_reg == PH_RSTOP_B) ? PH_RSTOP_C : PH_WSTOP_C;
                end
                PH_WSTOP_C: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                    wait_next  = cfg.wait_ticks;
                    phase_next = PH_WAIT;
                end
                PH_WAIT: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b0;
                    if (wait_reg <= 24'd1) begin
                        phase_next = PH_RSTART;
                    end else begin
                        wait_next = wait_reg - 24'd1;
                    end
                end
                PH_RAACK_HI: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b0;
                    if (sda_sample) begin
                        rerr_next  = 1'b1;
                        phase_next = PH_RSTOP_A;
                    end else begin
                        byte_next  = '0;
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_RDATA_LO;
                    end
                end
                PH_RDATA_HI: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                    shift_next = {shift_reg[6:0], sda_sample};
                    bit_next   = bit_reg + 3'd1;
                    if (bit_reg == 3'd7) begin
                        raw_next   = {raw_reg[15:0], shift_reg[6:0], sda_sample};
                        phase_next = PH_MACK_LO;
                    end else begin
                        phase_next = PH_RDATA_LO;
                    end
                end
                PH_MACK_LO: begin
                    scl_next   = 1'b0;
                    sda_next   = last;
                    drv_next   = 1'b1;
                    phase_next = PH_MACK_HI;
                end
                PH_MACK_HI: begin
                    scl_next = 1'b1;
                    sda_next = last;
                    drv_next = 1'b1;
                    if (last) begin
                        phase_next = PH_RSTOP_A;
                    end else begin
                        byte_next  = byte_reg + 2'd1;
                        shift_next = '0;
                        phase_next = PH_RDATA_LO;
                    end
                end
                PH_RSTOP_C: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                default: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        st1_next.scl   = scl_next;
        st1_next.sda   = sda_next;
        st1_next.drv   = drv_next;
        st1_next.busy  = phase_next != PH_IDLE;
        st1_next.done  = done;
        st1_next.wstat = done ? werr_next : WST_OK;
        st1_next.rstat = done && rerr_next;
        st1_next.raw   = done ? $signed(raw_next) : '0;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_ready) begin
            st1_valid_next = 1'b0;
        end else begin
            st1_valid_next = st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_reg       <= '0;
            byte_reg      <= '0;
            shift_reg     <= '0;
            raw_reg       <= '0;
            wait_reg      <= '0;
            werr_reg      <= WST_OK;
            rerr_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drv_reg       <= 1'b0;
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            if (accept) begin
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                byte_reg  <= byte_next;
                shift_reg <= shift_next;
                raw_reg   <= raw_next;
                wait_reg  <= wait_next;
                werr_reg  <= werr_next;
                rerr_reg  <= rerr_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                drv_reg   <= drv_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= st1_next;
        end
    end

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && st1_reg.done |-> !st1_reg.busy)
        else $error("completion word still marked busy");

    a_released_high: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !st1_reg.drv |-> st1_reg.sda)
        else $error("released data line not reported high");

    a_status_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !st1_reg.done |->
            st1_reg.wstat == WST_OK && !st1_reg.rstat && st1_reg.raw == '0)
        else $error("status fields set outside completion word");

    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && command && phase_reg != PH_IDLE |=> $stable(phase_reg))
        else $error("start taken while busy");

endmodule

/* rtl/i2cpp_scale.sv */
// ----------------------------------------------------------------------------
// i2cpp_scale
// Two-stage pressure scaling: split multiply, then sum, shift and saturate.
// ----------------------------------------------------------------------------
module i2cpp_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2cpp_pkg::cfg_t     cfg,
    input  logic                st1_valid,
    output logic                st1_ready,
    input  i2cpp_pkg::seq_res_t st1,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cpp_pkg::res_t     res
);
    import i2cpp_pkg::*;

    logic                     v2_reg, v3_reg;
    logic                     ready2, ready3;
    seq_res_t                 st2_reg;
    logic signed [PP_W-1:0]   pp_lo_reg, pp_hi_reg;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [Q_W-1:0]    q;
    logic signed [PRESS_W-1:0] sat;
    res_t                     res_reg;

    assign ready3    = !v3_reg || out_ready;
    assign ready2    = !v2_reg || ready3;
    assign st1_ready = ready2;
    assign out_valid = v3_reg;
    assign res       = res_reg;

    // Stage 2: offset removal and two half-width partial products
    assign diff = DIFF_W'(st1.raw) - DIFF_W'(cfg.zero_code);

    // Stage 3: recombine, floor shift, clamp
    assign prod = (PROD_W'(pp_hi_reg) <<< (GAIN_W / 2)) + PROD_W'(pp_lo_reg);
    assign q    = Q_W'(prod >>> SHIFT);

    always_comb begin
        if (q > Q_MAX) begin
            sat = PRESS_W'(Q_MAX);
        end else if (q < Q_MIN) begin
            sat = PRESS_W'(Q_MIN);
        end else begin
            sat = q[PRESS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready2) begin
                v2_reg <= st1_valid;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && st1_valid) begin
            st2_reg   <= st1;
            pp_lo_reg <= diff * $signed({1'b0, cfg.gain_q32[GAIN_W/2-1:0]});
            pp_hi_reg <= diff * $signed({1'b0, cfg.gain_q32[GAIN_W-1:GAIN_W/2]});
        end
        if (ready3 && v2_reg) begin
            res_reg.seq      <= st2_reg;
            res_reg.pressure <= st2_reg.done ? sat : '0;
        end
    end

    a_pressure_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !res_reg.seq.done |-> res_reg.pressure == '0)
        else $error("pressure set outside completion word");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && ready3 |=> v3_reg)
        else $error("middle stage word lost");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !ready3 |=> v2_reg && $stable(st2_reg))
        else $error("middle stage overwritten while stalled");

endmodule

/* rtl/i2c_pressure_sensor_poller.sv */
// ----------------------------------------------------------------------------
// i2c_pressure_sensor_poller
// I2C master that runs one pressure measurement per start word and scales it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_): one word per tick or command. s_tuser[0] = 1 starts a
//   measurement cycle (ignored while busy); 0 is a half-bit tick that carries
//   the sampled data line in s_tdata[0].
//   Master side (m_): exactly one result word per input word, in order, with
//   the clock/data line levels to drive, busy/done flags, and on the
//   completion word the write/read status, raw code and scaled pressure.
//   Configuration: cfg_index selects device address, command byte, wait
//   ticks, zero code or gain; other indexes are dropped. cfg_ready is always
//   high. Write only while no word is in flight.
// Throughput: one word per cycle while m_tready keeps the pipe moving; the
//   sequencer advances one bus phase per tick with no stall of its own.
// Pipeline: an accepted word passes the sequencer register, the
//   partial-product register and the output register, then shows on m_tvalid.
// Reset: aresetn low clears the sequencer to idle (lines released high) and
//   empties the pipe; configuration returns to its power-on values.
// Stalls: with m_tready low the output register holds; the two stages ahead
//   of it keep filling, then s_tready drops until space frees up.
// ----------------------------------------------------------------------------
module i2c_pressure_sensor_poller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2cpp_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] sda_sample, [7:1] zero
    input  logic                              s_tuser,   // [0] command
    // Master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2cpp_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] scl_level, [1] sda_level,
                                                         // [2] sda_drive, [3] busy_res,
                                                         // [4] done_res,
                                                         // [6:5] write_status,
                                                         // [7] read_status,
                                                         // [31:8] raw_value,
                                                         // [51:32] pressure,
                                                         // [55:52] zero
    // Configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [31:0]                       cfg_data
);
    import i2cpp_pkg::*;

    cfg_t     cfg;
    logic     st1_valid;
    logic     st1_ready;
    seq_res_t st1;
    res_t     res;

    // Hold configuration registers
    i2cpp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the bus sequencer one phase per accepted tick
    i2cpp_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .command    (s_tuser),
        .sda_sample (s_tdata[0]),
        .st1_valid  (st1_valid),
        .st1_ready  (st1_ready),
        .st1        (st1)
    );

    // Scale raw code to pressure behind the sequencer
    i2cpp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .st1_valid (st1_valid),
        .st1_ready (st1_ready),
        .st1       (st1),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    // Pack the result word, last field in the lowest bits
    assign m_tdata = {4'b0000,
                      res.pressure,
                      res.seq.raw,
                      res.seq.rstat,
                      res.seq.wstat,
                      res.seq.done,
                      res.seq.busy,
                      res.seq.drv,
                      res.seq.sda,
                      res.seq.scl};

endmodule

/* tb/i2c_pressure_sensor_poller_tb.sv */
// ----------------------------------------------------------------------------
// i2c_pressure_sensor_poller_tb
// Self-checking bench for the I2C pressure sensor poller.
// ----------------------------------------------------------------------------
// Builds whole measurement cycles (start word, then half-bit ticks with the
// sampled data line placed on every ACK slot and read bit), plus noise words
// and stray starts. A bus-sequencer predictor tracks each accepted word and
// queues the expected line levels, flags, status, raw code and pressure; the
// result side compares every returned word field by field. Settings change
// between phases, with the bus idle, and each phase uses its own mix of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module i2c_pressure_sensor_poller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cpp_pkg::*;

    // Word kinds on s_tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic RSTAT_OK       = 1'b0;
    localparam logic RSTAT_ADDR_NAK = 1'b1;

    // Register indexes above the last one are spare and must be dropped
    localparam int CFG_SPARE_FIRST = int'(CFG_GAIN) + 1;
    localparam int CFG_INDEX_TOP   = 7;

    // Power-on register values
    localparam logic [6:0]         RST_DEV_ADDR = 7'd120;
    localparam logic [7:0]         RST_MEAS_CMD = 8'd172;
    localparam logic [23:0]        RST_WAIT     = 24'd25000;
    localparam logic signed [23:0] RST_ZERO     = 24'sd1677722;
    localparam logic [31:0]        RST_GAIN     = 32'd640000;

    localparam longint PRESS_HI = (longint'(1) << (PRESS_W - 1)) - 1;
    localparam longint PRESS_LO = -(longint'(1) << (PRESS_W - 1));

    // Ticks from the first tick after a start to the final STOP tick, minus the wait
    localparam int CYCLE_TICKS = 134;

    localparam int ITEMS_PER_PHASE = 170;
    localparam int HOLD_AT_WORD    = 500;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [4:0] {
        BUS_IDLE, W_START, W_ADDR_LO, W_ADDR_HI, W_AACK_LO, W_AACK_HI,
        W_CMD_LO, W_CMD_HI, W_CACK_LO, W_CACK_HI, W_STOP_A, W_STOP_B, W_STOP_C,
        BUS_WAIT, R_START, R_ADDR_LO, R_ADDR_HI, R_AACK_LO, R_AACK_HI,
        R_DATA_LO, R_DATA_HI, M_ACK_LO, M_ACK_HI, R_STOP_A, R_STOP_B, R_STOP_C
    } bus_phase_e;

    typedef enum logic [1:0] {
        TRAFFIC_FREE, TRAFFIC_SENDER_GAPS, TRAFFIC_RECEIVER_STALLS, TRAFFIC_BOTH
    } traffic_mode_e;

    typedef enum logic [2:0] {
        CYC_CLEAN, CYC_ADDR_NAK, CYC_CMD_NAK, CYC_RADDR_NAK, CYC_BOTH_NAK, CYC_NOISE
    } cycle_kind_e;

    typedef struct {
        logic kind;
        logic sda;
    } poll_word_t;

    // Result word as laid out on m_tdata, lowest field last
    typedef struct packed {
        logic [3:0]                pad;
        logic signed [PRESS_W-1:0] pressure;
        logic signed [RAW_W-1:0]   raw;
        logic                      rstat;
        logic [1:0]                wstat;
        logic                      done;
        logic                      busy;
        logic                      drv;
        logic                      sda;
        logic                      scl;
    } line_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [0] sda_sample, [7:1] zero
    logic        s_tuser   = 1'b0; // [0] command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // [0] scl, [1] sda, [2] drive, [3] busy, [4] done,
                                   // [6:5] write status, [7] read status,
                                   // [31:8] raw, [51:32] pressure, [55:52] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    i2c_pressure_sensor_poller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shadow registers and bus-sequencer predictor
    // ------------------------------------------------------------------------
    logic [6:0]         sh_addr;
    logic [7:0]         sh_cmd;
    logic [23:0]        sh_wait;
    logic signed [23:0] sh_zero;
    logic [31:0]        sh_gain;

    bus_phase_e  bus_ph;
    logic [2:0]  bit_idx;
    logic [1:0]  byte_idx;
    logic [7:0]  shift_q;
    logic [31:0] frame_q;
    logic [23:0] wait_left;
    logic [1:0]  werr;
    logic        rerr;
    logic        scl_q, sda_q, drv_q;

    poll_word_t  pending_words[$];
    line_word_t  expected_lines[$];

    traffic_mode_e traffic_mode = TRAFFIC_FREE;
    logic          hold_rx      = 1'b0;
    int            words_queued = 0;
    int            words_taken  = 0;
    int            mismatches   = 0;
    int            cycles_built = 0;
    int unsigned   cycle_count  = 0;

    function automatic void reset_model();
        sh_addr   = RST_DEV_ADDR;
        sh_cmd    = RST_MEAS_CMD;
        sh_wait   = RST_WAIT;
        sh_zero   = RST_ZERO;
        sh_gain   = RST_GAIN;
        bus_ph    = BUS_IDLE;
        bit_idx   = '0;
        byte_idx  = '0;
        shift_q   = '0;
        frame_q   = '0;
        wait_left = '0;
        werr      = WST_OK;
        rerr      = RSTAT_OK;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        drv_q     = 1'b0;
    endfunction

    // A released line always reads back high
    function automatic void set_lines(input logic scl, input logic sda, input logic drv);
        scl_q = scl;
        sda_q = drv ? sda : 1'b1;
        drv_q = drv;
    endfunction

    // High half of a sent bit; true once the eighth bit is out
    function automatic logic send_high();
        set_lines(1'b1, shift_q[7], 1'b1);
        shift_q = {shift_q[6:0], 1'b0};
        bit_idx = bit_idx + 3'd1;
        return bit_idx == 3'd0;
    endfunction

    function automatic longint scaled_pressure(input longint raw);
        longint q;
        q = ((raw - longint'(sh_zero)) * longint'(sh_gain)) >>> SHIFT;
        if (q > PRESS_HI) q = PRESS_HI;
        if (q < PRESS_LO) q = PRESS_LO;
        return q;
    endfunction

    // Advance the sequencer by one word and return the line word it produces
    function automatic line_word_t advance_bus(input logic kind, input logic sda_in);
        line_word_t w;
        logic       finished;
        logic       last_byte;
        longint     raw;
        finished  = 1'b0;
        last_byte = (byte_idx == LAST_BYTE);
        if (kind == OP_START) begin
            if (bus_ph == BUS_IDLE) begin
                frame_q  = '0;
                werr     = WST_OK;
                rerr     = RSTAT_OK;
                bit_idx  = '0;
                byte_idx = '0;
                bus_ph   = W_START;
            end
        end else begin
            case (bus_ph)
                W_START: begin
                    set_lines(1'b1, 1'b0, 1'b1);
                    shift_q = {sh_addr, 1'b0};
                    bit_idx = '0;
                    bus_ph  = W_ADDR_LO;
                end
                W_ADDR_LO: begin
                    set_lines(1'b0, shift_q[7], 1'b1);
                    bus_ph = W_ADDR_HI;
                end
                W_ADDR_HI: bus_ph = send_high() ? W_AACK_LO : W_ADDR_LO;
                W_AACK_LO: begin
                    set_lines(1'b0, 1'b1, 1'b0);
                    bus_ph = W_AACK_HI;
                end
                W_AACK_HI: begin
                    set_lines(1'b1, 1'b1, 1'b0);
                    if (sda_in) begin
                        werr   = WST_ADDR_NAK;
                        bus_ph = W_STOP_A;
                    end else begin
                        shift_q = sh_cmd;
                        bit_idx = '0;
                        bus_ph  = W_CMD_LO;
                    end
                end
                W_CMD_LO: begin
                    set_lines(1'b0, shift_q[7], 1'b1);
                    bus_ph = W_CMD_HI;
                end
                W_CMD_HI: bus_ph = send_high() ? W_CACK_LO : W_CMD_LO;
                W_CACK_LO: begin
                    set_lines(1'b0, 1'b1, 1'b0);
                    bus_ph = W_CACK_HI;
                end
                W_CACK_HI: begin
                    set_lines(1'b1, 1'b1, 1'b0);
                    if (sda_in) werr = WST_CMD_NAK;
                    bus_ph = W_STOP_A;
                end
                W_STOP_A: begin
                    set_lines(1'b0, 1'b0, 1'b1);
                    bus_ph = W_STOP_B;
                end
                W_STOP_B: begin
                    set_lines(1'b1, 1'b0, 1'b1);
                    bus_ph = W_STOP_C;
                end
                W_STOP_C: begin
                    set_lines(1'b1, 1'b1, 1'b0);
                    wait_left = sh_wait;
                    bus_ph    = BUS_WAIT;
                end
                BUS_WAIT: begin
                    // A zero wait behaves like one tick
                    set_lines(1'b1, 1'b1, 1'b0);
                    if (wait_left <= 24'd1) bus_ph = R_START;
                    else wait_left = wait_left - 24'd1;
                end
                R_START: begin
                    set_lines(1'b1, 1'b0, 1'b1);
                    shift_q = {sh_addr, 1'b1};
                    bit_idx = '0;
                    bus_ph  = R_ADDR_LO;
                end
                R_ADDR_LO: begin
                    set_lines(1'b0, shift_q[7], 1'b1);
                    bus_ph = R_ADDR_HI;
                end
                R_ADDR_HI: bus_ph = send_high() ? R_AACK_LO : R_ADDR_LO;
                R_AACK_LO: begin
                    set_lines(1'b0, 1'b1, 1'b0);
                    bus_ph = R_AACK_HI;
                end
                R_AACK_HI: begin
                    set_lines(1'b1, 1'b1, 1'b0);
                    if (sda_in) begin
                        rerr   = RSTAT_ADDR_NAK;
                        bus_ph = R_STOP_A;
                    end else begin
                        byte_idx = '0;
                        bit_idx  = '0;
                        shift_q  = '0;
                        bus_ph   = R_DATA_LO;
                    end
                end
                R_DATA_LO: begin
                    set_lines(1'b0, 1'b1, 1'b0);
                    bus_ph = R_DATA_HI;
                end
                R_DATA_HI: begin
                    set_lines(1'b1, 1'b1, 1'b0);
                    shift_q = {shift_q[6:0], sda_in};
                    bit_idx = bit_idx + 3'd1;
                    if (bit_idx == 3'd0) begin
                        frame_q = {frame_q[23:0], shift_q};
                        bus_ph  = M_ACK_LO;
                    end else begin
                        bus_ph = R_DATA_LO;
                    end
                end
                M_ACK_LO: begin
                    set_lines(1'b0, last_byte, 1'b1);
                    bus_ph = M_ACK_HI;
                end
                M_ACK_HI: begin
                    set_lines(1'b1, last_byte, 1'b1);
                    if (last_byte) begin
                        bus_ph = R_STOP_A;
                    end else begin
                        byte_idx = byte_idx + 2'd1;
                        shift_q  = '0;
                        bus_ph   = R_DATA_LO;
                    end
                end
                R_STOP_A: begin
                    set_lines(1'b0, 1'b0, 1'b1);
                    bus_ph = R_STOP_B;
                end
                R_STOP_B: begin
                    set_lines(1'b1, 1'b0, 1'b1);
                    bus_ph = R_STOP_C;
                end
                R_STOP_C: begin
                    set_lines(1'b1, 1'b1, 1'b0);
                    bus_ph   = BUS_IDLE;
                    finished = 1'b1;
                end
                default: begin
                    set_lines(1'b1, 1'b1, 1'b0);
                    bus_ph = BUS_IDLE;
                end
            endcase
        end

        w      = '0;
        w.scl  = scl_q;
        w.sda  = sda_q;
        w.drv  = drv_q;
        w.busy = (bus_ph != BUS_IDLE);
        w.done = finished;
        if (finished) begin
            // Drop the status byte, keep the sign-extended low 24 bits
            raw        = longint'($signed(frame_q[23:0]));
            w.wstat    = werr;
            w.rstat    = rerr;
            w.raw      = frame_q[23:0];
            w.pressure = PRESS_W'(scaled_pressure(raw));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    function automatic void push_word(input logic kind, input logic sda);
        poll_word_t pw;
        pw.kind = kind;
        pw.sda  = sda;
        pending_words.push_back(pw);
        words_queued++;
    endfunction

    // Ticks whose data sample is ignored; slip in a stray start now and then
    function automatic void push_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(39) == 0) push_word(OP_START, 1'($urandom));
            push_word(OP_TICK, 1'($urandom));
        end
    endfunction

    // Low half with noise on the line, then the sampled high half
    function automatic void push_sampled(input logic v);
        push_word(OP_TICK, 1'($urandom));
        push_word(OP_TICK, v);
    endfunction

    function automatic void queue_cycle(input cycle_kind_e kind, input logic [31:0] data,
                                        input logic double_start);
        int   wait_eff;
        logic nak_addr, nak_cmd, nak_read;
        wait_eff = (sh_wait == 24'd0) ? 1 : int'(sh_wait);
        nak_addr = (kind == CYC_ADDR_NAK) || (kind == CYC_BOTH_NAK);
        nak_cmd  = (kind == CYC_CMD_NAK);
        nak_read = (kind == CYC_RADDR_NAK) || (kind == CYC_BOTH_NAK);
        cycles_built++;
        push_word(OP_START, 1'($urandom));
        if (double_start) push_word(OP_START, 1'($urandom));
        if (kind == CYC_NOISE) begin
            // Random line everywhere; long enough that any path reaches idle
            for (int i = 0; i < CYCLE_TICKS + wait_eff + int'($urandom_range(3)); i++)
                push_word(OP_TICK, 1'($urandom));
            return;
        end
        push_ticks(17);
        push_sampled(nak_addr);
        if (!nak_addr) begin
            push_ticks(16);
            push_sampled(nak_cmd);
        end
        push_ticks(3 + wait_eff + 1 + 16);
        push_sampled(nak_read);
        if (!nak_read) begin
            for (int b = 0; b < READ_BYTES; b++) begin
                for (int i = 0; i < 8; i++) push_sampled(data[31 - 8 * b - i]);
                push_ticks(2);
            end
        end
        push_ticks(3);
    endfunction

    function automatic logic [31:0] pick_frame();
        case ($urandom_range(11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hA580_0000;
            3:       return 32'h5A7F_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic cycle_kind_e pick_kind();
        int r;
        // The first few cycles walk through every error path once
        case (cycles_built)
            1: return CYC_ADDR_NAK;
            2: return CYC_CMD_NAK;
            3: return CYC_RADDR_NAK;
            4: return CYC_BOTH_NAK;
            5: return CYC_NOISE;
            default: ;
        endcase
        r = $urandom_range(99);
        if (r < 60) return CYC_CLEAN;
        if (r < 68) return CYC_ADDR_NAK;
        if (r < 76) return CYC_CMD_NAK;
        if (r < 84) return CYC_RADDR_NAK;
        if (r < 90) return CYC_BOTH_NAK;
        return CYC_NOISE;
    endfunction

    task automatic fill_phase();
        int start_count;
        start_count = words_queued;
        while (words_queued - start_count < ITEMS_PER_PHASE) begin
            push_ticks($urandom_range(3));
            queue_cycle(pick_kind(), pick_frame(), $urandom_range(3) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        // Mirror the write into the shadow copy; spare indexes change nothing
        case (idx)
            CFG_DEV_ADDR: sh_addr = val[6:0];
            CFG_MEAS_CMD: sh_cmd  = val[7:0];
            CFG_WAIT:     sh_wait = val[23:0];
            CFG_ZERO:     sh_zero = val[23:0];
            CFG_GAIN:     sh_gain = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Upper bits carry junk so register width masking gets exercised
    task automatic load_settings(input logic [6:0] addr, input logic [7:0] cmd,
                                 input logic [23:0] wait_t, input logic [23:0] zero,
                                 input logic [31:0] gain);
        write_reg(CFG_DEV_ADDR, {25'($urandom), addr});
        write_reg(CFG_MEAS_CMD, {24'($urandom), cmd});
        write_reg(CFG_WAIT, {8'($urandom), wait_t});
        write_reg(CFG_ZERO, {8'($urandom), zero});
        write_reg(CFG_GAIN, gain);
        @(negedge aclk);
    endtask

    // Hold until every queued word is taken and every result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_lines.size() != 0);
    endtask

    // Quiet bus between phases: drain, let the pipe empty, then retune
    task automatic next_phase(input traffic_mode_e mode);
        wait_drained();
        repeat (4) @(posedge aclk);
        traffic_mode = mode;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next pending word, hold it until taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        poll_word_t pw;
        int         gap_pct;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            reset_model();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_lines.push_back(advance_bus(s_tuser, s_tdata[0]));
                words_taken++;
            end
            gap_pct = (traffic_mode == TRAFFIC_SENDER_GAPS) ? 62 :
                      (traffic_mode == TRAFFIC_BOTH)        ? 13 : 0;
            // Advance only when nothing is on offer or the offer was just taken
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    pw = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= pw.kind;
                    s_tdata  <= {7'b0, pw.sda};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each returned word with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    task automatic check_line(input line_word_t want, input line_word_t got);
        if (got.scl !== want.scl)           note_mismatch("scl_level", want.scl, got.scl);
        if (got.sda !== want.sda)           note_mismatch("sda_level", want.sda, got.sda);
        if (got.drv !== want.drv)           note_mismatch("sda_drive", want.drv, got.drv);
        if (got.busy !== want.busy)         note_mismatch("busy", want.busy, got.busy);
        if (got.done !== want.done)         note_mismatch("done", want.done, got.done);
        if (got.wstat !== want.wstat)       note_mismatch("write_status", want.wstat, got.wstat);
        if (got.rstat !== want.rstat)       note_mismatch("read_status", want.rstat, got.rstat);
        if (got.raw !== want.raw)           note_mismatch("raw_value", want.raw, got.raw);
        if (got.pressure !== want.pressure) note_mismatch("pressure", want.pressure, got.pressure);
        if (got.pad !== want.pad)           note_mismatch("tdata pad", want.pad, got.pad);
    endtask

    always @(posedge aclk) begin
        int stall_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_lines.size() == 0)
                    note_mismatch("unexpected result word", '0, m_tdata);
                else
                    check_line(expected_lines.pop_front(), m_tdata);
            end
            stall_pct = (traffic_mode == TRAFFIC_RECEIVER_STALLS) ? 62 :
                        (traffic_mode == TRAFFIC_BOTH)            ? 13 : 0;
            m_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
        end
    end

    // Long receiver hold-off while the sender keeps offering: fills the pipe
    // and forces s_tready low
    initial begin
        do @(negedge aclk); while (words_taken < HOLD_AT_WORD);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero wait only; address, command, zero and gain stay at power-on values
        traffic_mode = TRAFFIC_FREE;
        write_reg(CFG_WAIT, {8'($urandom), 24'd0});
        @(negedge aclk);
        // Idle ticks with both line levels, then a start hit by a second start
        push_word(OP_TICK, 1'b0);
        push_word(OP_TICK, 1'b1);
        push_word(OP_START, 1'b1);
        push_word(OP_START, 1'b0);
        push_ticks(1);
        push_word(OP_START, 1'b1);
        push_ticks(CYCLE_TICKS);
        push_word(OP_TICK, 1'b0);
        push_word(OP_TICK, 1'b1);
        fill_phase();

        // Low extremes of address and command, widest positive span
        next_phase(TRAFFIC_SENDER_GAPS);
        load_settings(7'd0, 8'd0, 24'd1, 24'h80_0000, 32'hFFFF_FFFF);
        fill_phase();

        // High extremes, widest negative span; spare indexes must be dropped
        next_phase(TRAFFIC_RECEIVER_STALLS);
        load_settings(7'd127, 8'd255, 24'd3, 24'h7F_FFFF, 32'hFFFF_FFFF);
        for (int i = CFG_SPARE_FIRST; i <= CFG_INDEX_TOP; i++)
            write_reg(3'(i), $urandom);
        @(negedge aclk);
        fill_phase();

        next_phase(TRAFFIC_BOTH);
        load_settings(7'($urandom), 8'($urandom), 24'($urandom_range(6, 1)),
                      24'($urandom), $urandom);
        fill_phase();

        // Zero gain; park the longest wait, then replace it before any cycle
        next_phase(TRAFFIC_FREE);
        load_settings(7'($urandom), 8'($urandom), 24'hFF_FFFF, 24'd0, 32'd0);
        write_reg(CFG_WAIT, {8'($urandom), 24'd4});
        @(negedge aclk);
        fill_phase();

        // Unit gain: pressure follows the raw code minus the zero code until it saturates
        next_phase(TRAFFIC_SENDER_GAPS);
        load_settings(7'($urandom), 8'($urandom), 24'd2, RST_ZERO, 32'h0100_0000);
        fill_phase();

        next_phase(TRAFFIC_BOTH);
        load_settings(RST_DEV_ADDR, RST_MEAS_CMD, 24'd5, RST_ZERO, RST_GAIN);
        fill_phase();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_lines.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* i2c_pressure_sensor_poller.f */
rtl/i2cpp_pkg.sv
rtl/i2cpp_cfg.sv
rtl/i2cpp_seq.sv
rtl/i2cpp_scale.sv
rtl/i2c_pressure_sensor_poller.sv
tb/i2c_pressure_sensor_poller_tb.sv
